// ===== hdl/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing test.
// No dependencies.
package pip_pkg;

    localparam int TAG_BITS = 8;

    typedef logic [TAG_BITS-1:0] tag_t;

endpackage

// ===== hdl/pip_if.sv =====
// Valid/ready channel interfaces for vertex items and result items.
// Depends on pip_pkg.
interface pip_vertex_if
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;
    tag_t                         polygon_tag;

    modport source (
        output valid, point_x, point_y, vertex_x, vertex_y, last_vertex, polygon_tag,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, vertex_x, vertex_y, last_vertex, polygon_tag,
        output ready
    );
endinterface

interface pip_result_if
    import pip_pkg::*;
;
    logic valid;
    logic ready;
    logic inside_res;
    tag_t result_tag;

    modport source (
        output valid, inside_res, result_tag,
        input  ready
    );
    modport sink (
        input  valid, inside_res, result_tag,
        output ready
    );
endinterface

// ===== hdl/point_in_polygon_crossing_test.sv =====
// An accepted last vertex passes the stage 1 and stage 2 registers before its result reaches the output register.
// Throughput: one vertex item per cycle; the pipeline stalls only while a
// result waits on the output register.
// Each item tests the current edge and the closing edge in parallel:
// subtract, then registered products, then compare and parity update.
// Reset (rst_n low, asynchronous) clears all valid bits, the parity and the polygon state.
// Depends on pip_pkg and pip_if.
module point_in_polygon_crossing_test
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    pip_vertex_if.sink    vertices,
    pip_result_if.source  results
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         diff_t;
    typedef logic signed [PW-1:0]         prod_t;

    logic advance;
    logic accept;

    // polygon tracking at the input side
    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic   mid_polygon_reg;

    // stage 1: item with both edge end points
    logic   s1_valid_reg;
    coord_t s1_px_reg, s1_py_reg, s1_cx_reg, s1_cy_reg;
    coord_t s1_ax_reg, s1_ay_reg, s1_fx_reg, s1_fy_reg;
    logic   s1_mid_reg, s1_last_reg;
    tag_t   s1_tag_reg;

    // stage 2: span hits, dx sign, products
    logic   s2_valid_reg;
    logic   s2_start_reg, s2_last_reg;
    logic   s2_hit1_reg, s2_hit2_reg, s2_dxpos1_reg, s2_dxpos2_reg;
    prod_t  s2_l1_reg, s2_r1_reg, s2_l2_reg, s2_r2_reg;
    tag_t   s2_tag_reg;

    // stage 3: parity and output register
    logic   parity_reg;
    logic   out_valid_reg;
    logic   out_inside_reg;
    tag_t   out_tag_reg;

    assign advance        = !out_valid_reg || results.ready;
    assign accept         = vertices.valid && advance;
    assign vertices.ready = advance;

    assign results.valid      = out_valid_reg;
    assign results.inside_res = out_inside_reg;
    assign results.result_tag = out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg     <= '0;
            first_y_reg     <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            mid_polygon_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!mid_polygon_reg)
            begin
                first_x_reg <= vertices.vertex_x;
                first_y_reg <= vertices.vertex_y;
            end
            prev_x_reg      <= vertices.vertex_x;
            prev_y_reg      <= vertices.vertex_y;
            mid_polygon_reg <= !vertices.last_vertex;
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= vertices.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= vertices.point_x;
            s1_py_reg   <= vertices.point_y;
            s1_cx_reg   <= vertices.vertex_x;
            s1_cy_reg   <= vertices.vertex_y;
            s1_ax_reg   <= prev_x_reg;
            s1_ay_reg   <= prev_y_reg;
            s1_fx_reg   <= mid_polygon_reg ? first_x_reg : vertices.vertex_x;
            s1_fy_reg   <= mid_polygon_reg ? first_y_reg : vertices.vertex_y;
            s1_mid_reg  <= mid_polygon_reg;
            s1_last_reg <= vertices.last_vertex;
            s1_tag_reg  <= vertices.polygon_tag;
        end
    end

    // stage 2: edge 1 runs prev -> cur, edge 2 runs cur -> first
    diff_t px_d, py_d, cx_d, cy_d, ax_d, ay_d, fx_d, fy_d;
    diff_t dx1, dx2, ly1, ly2, ry1, ry2, rx1, rx2;
    logic  span1, span2;

    always_comb
    begin
        px_d  = DW'(s1_px_reg);
        py_d  = DW'(s1_py_reg);
        cx_d  = DW'(s1_cx_reg);
        cy_d  = DW'(s1_cy_reg);
        ax_d  = DW'(s1_ax_reg);
        ay_d  = DW'(s1_ay_reg);
        fx_d  = DW'(s1_fx_reg);
        fy_d  = DW'(s1_fy_reg);
        span1 = (s1_px_reg >= s1_cx_reg && s1_px_reg < s1_ax_reg)
             || (s1_px_reg < s1_cx_reg && s1_px_reg >= s1_ax_reg);
        span2 = (s1_px_reg >= s1_fx_reg && s1_px_reg < s1_cx_reg)
             || (s1_px_reg < s1_fx_reg && s1_px_reg >= s1_cx_reg);
        dx1   = cx_d - ax_d;
        ly1   = py_d - cy_d;
        ry1   = cy_d - ay_d;
        rx1   = px_d - cx_d;
        dx2   = fx_d - cx_d;
        ly2   = py_d - fy_d;
        ry2   = fy_d - cy_d;
        rx2   = px_d - fx_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_start_reg  <= !s1_mid_reg;
            s2_last_reg   <= s1_last_reg;
            s2_hit1_reg   <= s1_mid_reg && span1;
            s2_hit2_reg   <= s1_last_reg && span2;
            s2_dxpos1_reg <= !dx1[DW-1] && (dx1 != '0);
            s2_dxpos2_reg <= !dx2[DW-1] && (dx2 != '0);
            s2_l1_reg     <= ly1 * dx1;
            s2_r1_reg     <= ry1 * rx1;
            s2_l2_reg     <= ly2 * dx2;
            s2_r2_reg     <= ry2 * rx2;
            s2_tag_reg    <= s1_tag_reg;
        end
    end

    // stage 3: compare, toggle parity, load result
    logic cross1, cross2, parity_base, parity_next;

    always_comb
    begin
        cross1      = s2_hit1_reg && (s2_dxpos1_reg ? (s2_l1_reg <= s2_r1_reg)
                                                    : (s2_l1_reg >= s2_r1_reg));
        cross2      = s2_hit2_reg && (s2_dxpos2_reg ? (s2_l2_reg <= s2_r2_reg)
                                                    : (s2_l2_reg >= s2_r2_reg));
        parity_base = s2_start_reg ? 1'b0 : parity_reg;
        parity_next = parity_base ^ cross1 ^ cross2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg)
                parity_reg <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg && s2_last_reg)
        begin
            out_inside_reg <= parity_next;
            out_tag_reg    <= s2_tag_reg;
        end
    end

endmodule

// ===== hdl/pip_checker.sv =====
// Port-level checks for the point-in-polygon crossing test, bound to point_in_polygon_crossing_test.
// Depends on pip_pkg and point_in_polygon_crossing_test.
module pip_checker
    import pip_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_inside,
    input tag_t out_tag
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_inside) && $stable(out_tag))
        else $error("stalled result changed");

    // back-pressure only from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // reset clears the output
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind point_in_polygon_crossing_test pip_checker u_pip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vertices.valid),
    .in_ready   (vertices.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_inside (results.inside_res),
    .out_tag    (results.result_tag)
);

// ===== bench/tb.sv =====
// Self-checking bench for point_in_polygon_crossing_test: streams polygons vertex by vertex
// and checks each inside/outside verdict against an in-bench even-odd crossing predictor.
// Depends on pip_pkg, pip_if and the point_in_polygon_crossing_test RTL.
`timescale 1ns / 100ps

module tb;
    import pip_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic is_in;
        tag_t tag;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    pip_vertex_if #(.COORD_BITS(COORD_BITS)) vertices ();
    pip_result_if results ();

    point_in_polygon_crossing_test #(.COORD_BITS(COORD_BITS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertices (vertices.sink),
        .results  (results.source)
    );

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int vertices_sent  = 0;
    int polygons_seen  = 0;
    int verdicts_seen  = 0;
    int mismatches     = 0;

    verdict_t pending_verdicts[$];
    verdict_t oldest_verdict;

    coord_t first_x = '0;
    coord_t first_y = '0;
    coord_t prev_x  = '0;
    coord_t prev_y  = '0;
    logic   parity  = 1'b0;
    logic   polygon_open = 1'b0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        results.ready = 1'b0;
        forever begin
            @(negedge clk);
            results.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic bit edge_crosses(input int px, input int py, input int ax,
                                        input int ay, input int bx, input int by);
        int     dx;
        longint lhs;
        longint rhs;
        if (!((px >= bx && px < ax) || (px < bx && px >= ax)))
            return 1'b0;
        dx  = bx - ax;
        lhs = longint'(py - by) * dx;
        rhs = longint'(by - ay) * (px - bx);
        return (dx > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    function automatic void advance_polygon(input coord_t px, input coord_t py,
                                            input coord_t vx, input coord_t vy,
                                            input logic last, input tag_t tag);
        if (!polygon_open) begin
            first_x = vx;
            first_y = vy;
            parity  = 1'b0;
        end
        else if (edge_crosses(px, py, prev_x, prev_y, vx, vy)) begin
            parity = ~parity;
        end
        prev_x = vx;
        prev_y = vy;
        if (!last) begin
            polygon_open = 1'b1;
        end
        else begin
            if (edge_crosses(px, py, vx, vy, first_x, first_y))
                parity = ~parity;
            pending_verdicts.push_back('{is_in: parity, tag: tag});
            polygons_seen++;
            polygon_open = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk) begin
        if (rst_n && vertices.valid && vertices.ready)
            advance_polygon(vertices.point_x, vertices.point_y, vertices.vertex_x,
                            vertices.vertex_y, vertices.last_vertex, vertices.polygon_tag);
    end

    always @(posedge clk) begin
        if (rst_n && results.valid && results.ready) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result with no polygon pending, tag %0d",
                                          results.result_tag));
            end
            else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (results.inside_res !== oldest_verdict.is_in)
                    report_mismatch($sformatf("inside_res %b expected %b (tag %0d)",
                                              results.inside_res, oldest_verdict.is_in,
                                              oldest_verdict.tag));
                if (results.result_tag !== oldest_verdict.tag)
                    report_mismatch($sformatf("result_tag %0d expected %0d",
                                              results.result_tag, oldest_verdict.tag));
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((vertices.valid && vertices.ready) || (results.valid && results.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_vertex(input coord_t px, input coord_t py, input coord_t vx,
                               input coord_t vy, input logic last, input tag_t tag);
        while ($urandom_range(99) < send_idle_pct) begin
            vertices.valid = 1'b0;
            @(negedge clk);
        end
        vertices.valid       = 1'b1;
        vertices.point_x     = px;
        vertices.point_y     = py;
        vertices.vertex_x    = vx;
        vertices.vertex_y    = vy;
        vertices.last_vertex = last;
        vertices.polygon_tag = tag;
        @(posedge clk);
        while (!vertices.ready)
            @(posedge clk);
        vertices_sent++;
        @(negedge clk);
    endtask

    function automatic int rand_offset(input int radius);
        return int'($urandom_range(2 * radius)) - radius;
    endfunction

    task automatic send_random_polygon();
        int     count;
        int     radius;
        int     cx;
        int     cy;
        coord_t px;
        coord_t py;
        tag_t   tag;
        count  = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        radius = 1 << $urandom_range(2, 14);
        cx     = int'($urandom_range(65535)) - 32768;
        cy     = int'($urandom_range(65535)) - 32768;
        px     = coord_t'(cx + rand_offset(radius));
        py     = coord_t'(cy + rand_offset(radius));
        tag    = tag_t'($urandom_range(255));
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) begin
                px = coord_t'(cx + rand_offset(radius));
                py = coord_t'(cy + rand_offset(radius));
            end
            send_vertex(px, py, coord_t'(cx + rand_offset(radius)),
                        coord_t'(cy + rand_offset(radius)), k == count - 1,
                        (k == count - 1) ? tag : tag_t'($urandom_range(255)));
        end
    endtask

    task automatic send_noise_vertex();
        send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), $urandom_range(3) == 0,
                    tag_t'($urandom_range(255)));
    endtask

    task automatic run_random_stream(input int item_count);
        int start;
        start = vertices_sent;
        while (vertices_sent - start < item_count) begin
            if ($urandom_range(4) == 0)
                send_noise_vertex();
            else
                send_random_polygon();
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // one-vertex polygon at the coordinate extremes
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1, 8'd0);
        // square around the point
        send_vertex(16'sd0, 16'sd0, -16'sd16, -16'sd16, 1'b0, 8'd1);
        send_vertex(16'sd0, 16'sd0, 16'sd16, -16'sd16, 1'b0, 8'd2);
        send_vertex(16'sd0, 16'sd0, 16'sd16, 16'sd16, 1'b0, 8'd3);
        send_vertex(16'sd0, 16'sd0, -16'sd16, 16'sd16, 1'b1, 8'd255);
        // full-range triangle
        send_vertex(16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b0, 8'd0);
        send_vertex(16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 1'b0, 8'd0);
        send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b1, 8'hAA);
        // vertical segment through the point
        send_vertex(16'sd5, 16'sd50, 16'sd5, 16'sd0, 1'b0, 8'd0);
        send_vertex(16'sd5, 16'sd50, 16'sd5, 16'sd100, 1'b1, 8'h55);
        // point moves while the polygon streams in
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 8'd0);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 8'd0);
        send_vertex(16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0, 8'd0);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1, 8'd17);
        // point on a corner, then on the left edge
        send_vertex(16'sd16, 16'sd16, -16'sd16, -16'sd16, 1'b0, 8'd0);
        send_vertex(16'sd16, 16'sd16, 16'sd16, -16'sd16, 1'b0, 8'd0);
        send_vertex(-16'sd16, 16'sd0, 16'sd16, 16'sd16, 1'b0, 8'd0);
        send_vertex(-16'sd16, 16'sd0, -16'sd16, 16'sd16, 1'b1, 8'd128);
        // point on a sloped edge line
        send_vertex(16'sd8, 16'sd8, 16'sd0, 16'sd0, 1'b0, 8'd0);
        send_vertex(16'sd8, 16'sd8, 16'sd16, 16'sd16, 1'b0, 8'd0);
        send_vertex(16'sd8, 16'sd8, 16'sd16, 16'sd0, 1'b1, 8'd127);
    endtask

    task automatic test_steady_stream();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_stream(500);
    endtask

    task automatic test_sparse_sender();
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        run_random_stream(500);
    endtask

    task automatic test_stalled_receiver();
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        run_random_stream(500);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        run_random_stream(500);
    endtask

    initial begin
        rst_n                = 1'b0;
        vertices.valid       = 1'b0;
        vertices.point_x     = '0;
        vertices.point_y     = '0;
        vertices.vertex_x    = '0;
        vertices.vertex_y    = '0;
        vertices.last_vertex = 1'b0;
        vertices.polygon_tag = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_steady_stream();
        test_sparse_sender();
        test_stalled_receiver();
        test_both_idle();

        vertices.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d vertex items in %0d polygons, %0d verdicts checked, %0d mismatches",
                 vertices_sent, polygons_seen, verdicts_seen, mismatches);
        $display("tb: covered directed edge cases and four sender/receiver idling mixes");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
